// ===== rtl/aspq_pkg.sv =====
// ----------------------------------------------------------------------------
// aspq_pkg: shared types for the aging sorted priority queue
// Request kinds, cell commands and the entry record held by each cell.
// ----------------------------------------------------------------------------
package aspq_pkg;

	localparam int TIME_W = 32;
	localparam int OCC_W  = 5;

	typedef logic [1:0]        kind_t;
	typedef logic [TIME_W-1:0] time_t;

	localparam kind_t KIND_ARRIVAL   = 2'd0;
	localparam kind_t KIND_DEPARTURE = 2'd1;
	localparam kind_t KIND_ELAPSE    = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP,
		OP_AGE
	} op_t;

	typedef struct packed {
		op_t   op;
		time_t arrival;
		time_t service;
		time_t elapsed;
	} cell_cmd_t;

	typedef struct packed {
		time_t arrival;
		time_t remaining;
	} entry_t;

endpackage

// ===== rtl/aspq_if.sv =====
// ----------------------------------------------------------------------------
// aspq_if: request and response channels
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface aspq_req_if;
	logic                valid;
	logic                ready;
	aspq_pkg::kind_t     kind;
	aspq_pkg::time_t     job_arrival_time;
	aspq_pkg::time_t     job_service_time;
	aspq_pkg::time_t     elapsed_time;

	modport source (output valid, kind, job_arrival_time, job_service_time, elapsed_time,
		input ready);
	modport sink (input valid, kind, job_arrival_time, job_service_time, elapsed_time,
		output ready);
endinterface

interface aspq_rsp_if;
	logic                valid;
	logic                ready;
	aspq_pkg::time_t     departed_arrival;
	logic                was_empty;
	logic                dropped_full;
	logic [4:0]          occupancy;

	modport source (output valid, departed_arrival, was_empty, dropped_full, occupancy,
		input ready);
	modport sink (input valid, departed_arrival, was_empty, dropped_full, occupancy,
		output ready);
endinterface

// ===== rtl/aspq_cell.sv =====
// ----------------------------------------------------------------------------
// aspq_cell: one slot of the sorted chain
// Holds one job and, on each command, keeps it, takes the new job, takes the
// left or right neighbor's job, or ages its remaining time.
// ----------------------------------------------------------------------------
module aspq_cell (
	input  logic                clk,
	input  aspq_pkg::cell_cmd_t cmd,
	input  logic                occupied,
	input  logic                prev_le,
	input  aspq_pkg::entry_t    left,
	input  aspq_pkg::entry_t    right,
	output aspq_pkg::entry_t    entry,
	output logic                le
);
	import aspq_pkg::*;

	entry_t entry_q;

	assign entry = entry_q;
	// The job stays here when it sorts at or before the incoming one.
	assign le    = occupied && (entry_q.remaining <= cmd.service);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_INSERT: begin
				if (!le) begin
					if (prev_le) begin
						entry_q.arrival   <= cmd.arrival;
						entry_q.remaining <= cmd.service;
					end else begin
						entry_q <= left;
					end
				end
			end
			OP_POP: entry_q <= right;
			OP_AGE: begin
				entry_q.remaining <= (entry_q.remaining > cmd.elapsed) ?
					(entry_q.remaining - cmd.elapsed) : '0;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/aging_sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// aging_sorted_priority_queue_unit: shortest remaining time job queue
// Row of cells kept in ascending remaining time, with a count and a
// registered response stage.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle while the sink keeps taking responses, and
// returns one response for each in the cycle after the request is taken. Every
// cell of the chain updates in the same cycle (insert with shift, pop with
// shift, or aging of all entries). A new request is taken in the same cycle
// that the sink takes a waiting response, and the input stalls for as long as
// the sink holds off a response. A new arrival
// goes behind all jobs with equal or shorter remaining time; arrivals into a
// full queue are dropped and flagged, departures from an empty queue return
// zero and flag empty, and aging saturates at zero. Occupancy is reported
// modulo 32.
module aging_sorted_priority_queue_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	aspq_req_if.sink   req,
	aspq_rsp_if.source rsp
);
	import aspq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          rsp_valid_q;
	time_t         departed_q;
	logic          empty_q;
	logic          dropped_q;
	logic [OCC_W-1:0] occ_q;

	logic          accept;
	logic          full;
	logic          none;
	logic          dropped;
	logic          empty;
	cell_cmd_t     cmd;
	entry_t        ent [QUEUE_DEPTH];
	logic          le  [QUEUE_DEPTH];
	logic [CW+OCC_W-1:0] occ_wide;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == FULL_COUNT);
	assign none      = (count_q == '0);
	assign dropped   = (req.kind == KIND_ARRIVAL) && full;
	assign empty     = (req.kind == KIND_DEPARTURE) && none;

	always_comb begin
		cmd.arrival = req.job_arrival_time;
		cmd.service = req.job_service_time;
		cmd.elapsed = req.elapsed_time;
		cmd.op      = OP_HOLD;
		count_next  = count_q;
		if (accept) begin
			if (req.kind == KIND_ARRIVAL && !full) begin
				cmd.op     = OP_INSERT;
				count_next = count_q + 1'b1;
			end else if (req.kind == KIND_DEPARTURE && !none) begin
				cmd.op     = OP_POP;
				count_next = count_q - 1'b1;
			end else if (req.kind == KIND_ELAPSE) begin
				cmd.op = OP_AGE;
			end
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		aspq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (count_q > CW'(i)),
			.prev_le  ((i == 0) ? 1'b1 : le[(i == 0) ? 0 : i-1]),
			.left     ((i == 0) ? entry_t'('0) : ent[(i == 0) ? 0 : i-1]),
			.right    ((i == QUEUE_DEPTH-1) ? entry_t'('0)
				: ent[(i == QUEUE_DEPTH-1) ? i : i+1]),
			.entry    (ent[i]),
			.le       (le[i])
		);
	end

	assign occ_wide = {{OCC_W{1'b0}}, count_next};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			departed_q <= (req.kind == KIND_DEPARTURE && !none) ? ent[0].arrival : '0;
			empty_q    <= empty;
			dropped_q  <= dropped;
			occ_q      <= occ_wide[OCC_W-1:0];
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.departed_arrival = departed_q;
	assign rsp.was_empty        = empty_q;
	assign rsp.dropped_full     = dropped_q;
	assign rsp.occupancy        = occ_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("job count exceeds queue depth");

	a_drop_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && dropped |=> count_q == $past(count_q))
		else $error("dropped arrival changed the job count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.kind == KIND_DEPARTURE && !none |=> count_q == $past(count_q) - 1'b1)
		else $error("departure did not remove exactly one job");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> ent[0].remaining <= ent[1].remaining)
		else $error("head of queue out of order");
`endif

endmodule
